### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; every macro samples on aclk and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define XBF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("xbf assertion failed");

// Next-cycle implication.
`define XBF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("xbf assertion failed");

`endif

### rtl/core/xbf_pkg.sv
// Shared types and constants for the XMODEM block framer.
// No dependencies.
package xbf_pkg;

    // operation codes on the input channel
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_EOF  = 2'd1;
    localparam logic [1:0] OP_PULL = 2'd2;

    localparam logic [7:0]  SOH_BYTE = 8'h01;
    localparam logic [7:0]  EOT_BYTE = 8'h04;
    localparam logic [7:0]  PAD_BYTE = 8'h1A;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // byte slots of one command: 0..2 header, 3 data/single byte, 4..5 trailer
    localparam int NUM_SLOTS = 6;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]      mask;   // slots that go on the line
        logic                      done;   // last sent slot ends the transfer
        logic [NUM_SLOTS-1:0][7:0] bytes;
    } xbf_cmd_t;

endpackage

### rtl/core/xbf_front.sv
// Front end: takes input transactions, tracks block state and CRC/sum,
// and emits at most one byte-slot command per transaction. Depends on xbf_pkg.
module xbf_front
    import xbf_pkg::*;
#(
    parameter int CHUNK_BYTES = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [1:0] operation,
    input  logic [7:0] data_byte,
    input  logic       use_crc,
    output logic       cmd_push,
    output xbf_cmd_t   cmd
);

    localparam int CNT_W = $clog2(CHUNK_BYTES + 1);

    typedef enum logic [6:0] {
        PH_STREAM   = 7'b0000001,
        PH_PAD      = 7'b0000010,
        PH_TRAIL_HI = 7'b0000100,
        PH_TRAIL_LO = 7'b0001000,
        PH_EOT1     = 7'b0010000,
        PH_EOT2     = 7'b0100000,
        PH_DONE     = 7'b1000000
    } phase_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    phase_t            phase_reg, phase_next;
    logic [7:0]        blk_reg, blk_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        sum_reg, sum_next;
    logic [15:0]       crc_reg, crc_next;

    logic [7:0]        abs_byte;
    logic [7:0]        sum_abs;
    logic [15:0]       crc_abs;
    logic [CNT_W-1:0]  cnt_abs;
    logic              fill;
    logic              close;

    assign abs_byte = (operation == OP_DATA) ? data_byte : PAD_BYTE;
    assign sum_abs  = sum_reg + abs_byte;
    assign crc_abs  = crc_byte(crc_reg, abs_byte);
    assign cnt_abs  = cnt_reg + CNT_W'(1);
    assign fill     = (cnt_abs == CNT_W'(CHUNK_BYTES));

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        crc_next   = crc_reg;
        close      = 1'b0;
        cmd        = '0;
        case (operation)
            OP_DATA: begin
                if (phase_reg == PH_STREAM) begin
                    if (cnt_reg == '0) begin
                        cmd.mask[2:0] = 3'b111;
                        cmd.bytes[0]  = SOH_BYTE;
                        cmd.bytes[1]  = blk_reg;
                        cmd.bytes[2]  = ~blk_reg;
                    end
                    cmd.mask[3]  = 1'b1;
                    cmd.bytes[3] = data_byte;
                    if (fill) begin
                        close = 1'b1;
                        if (use_crc) begin
                            cmd.mask[5:4] = 2'b11;
                            cmd.bytes[4]  = crc_abs[15:8];
                            cmd.bytes[5]  = crc_abs[7:0];
                        end else begin
                            cmd.mask[4]  = 1'b1;
                            cmd.bytes[4] = sum_abs;
                        end
                    end else begin
                        cnt_next = cnt_abs;
                        sum_next = sum_abs;
                        crc_next = crc_abs;
                    end
                end
            end
            OP_EOF: begin
                if (phase_reg == PH_STREAM) begin
                    if (cnt_reg == '0) begin
                        cmd.mask[4:3] = 2'b11;
                        cmd.bytes[3]  = EOT_BYTE;
                        cmd.bytes[4]  = EOT_BYTE;
                        cmd.done      = 1'b1;
                        phase_next    = PH_DONE;
                    end else begin
                        phase_next = PH_PAD;
                    end
                end
            end
            OP_PULL: begin
                cmd.mask[3] = (phase_reg != PH_STREAM) && (phase_reg != PH_DONE);
                case (phase_reg)
                    PH_PAD: begin
                        cmd.bytes[3] = PAD_BYTE;
                        cnt_next     = cnt_abs;
                        sum_next     = sum_abs;
                        crc_next     = crc_abs;
                        if (fill) begin
                            phase_next = PH_TRAIL_HI;
                        end
                    end
                    PH_TRAIL_HI: begin
                        if (use_crc) begin
                            cmd.bytes[3] = crc_reg[15:8];
                            phase_next   = PH_TRAIL_LO;
                        end else begin
                            cmd.bytes[3] = sum_reg;
                            close        = 1'b1;
                            phase_next   = PH_EOT1;
                        end
                    end
                    PH_TRAIL_LO: begin
                        cmd.bytes[3] = crc_reg[7:0];
                        close        = 1'b1;
                        phase_next   = PH_EOT1;
                    end
                    PH_EOT1: begin
                        cmd.bytes[3] = EOT_BYTE;
                        phase_next   = PH_EOT2;
                    end
                    PH_EOT2: begin
                        cmd.bytes[3] = EOT_BYTE;
                        cmd.done     = 1'b1;
                        phase_next   = PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        blk_next = blk_reg;
        if (close) begin
            blk_next = blk_reg + 8'd1;
            cnt_next = '0;
            sum_next = '0;
            crc_next = '0;
        end
    end

    assign cmd_push = accept && (cmd.mask != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_STREAM;
            blk_reg   <= 8'd1;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            crc_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            blk_reg   <= blk_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

### rtl/core/xbf_queue.sv
// Small command FIFO between front end and serializer.
// Depends on xbf_pkg for the command type.
module xbf_queue
    import xbf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  xbf_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output xbf_cmd_t head,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xbf_cmd_t          slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/core/xbf_back.sv
// Back end: serializes queued commands into line bytes, one per cycle while
// m_ready does not stall, through a registered output stage. Depends on xbf_pkg.
module xbf_back
    import xbf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  xbf_cmd_t   head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic       m_transfer_done
);

    xbf_cmd_t             cur_reg;
    logic [NUM_SLOTS-1:0] rem_reg, rem_next;
    logic [NUM_SLOTS-1:0] low, rem_left;
    logic [7:0]           sel_byte;
    logic                 emit, emit_last;
    logic                 m_valid_reg;
    logic [7:0]           m_frame_byte_reg;
    logic                 m_transfer_done_reg;

    // lowest pending slot goes out first
    assign low      = rem_reg & (~rem_reg + NUM_SLOTS'(1));
    assign rem_left = rem_reg & ~low;

    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            sel_byte = sel_byte | (cur_reg.bytes[i] & {8{low[i]}});
        end
    end

    assign emit      = (rem_reg != '0) && (!m_valid_reg || m_ready);
    assign emit_last = emit && (rem_left == '0);
    assign q_pop     = !q_empty && ((rem_reg == '0) || emit_last);

    always_comb begin
        rem_next = rem_reg;
        if (q_pop) begin
            rem_next = head.mask;
        end else if (emit) begin
            rem_next = rem_left;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= head;
        end
        if (emit) begin
            m_frame_byte_reg    <= sel_byte;
            m_transfer_done_reg <= cur_reg.done && (rem_left == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rem_reg <= rem_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_byte    = m_frame_byte_reg;
    assign m_transfer_done = m_transfer_done_reg;

endmodule

### rtl/core/xmodem_block_framer_unit.sv
// XMODEM sender block framer. Each input transaction carries an operation:
// a file data byte, end of file, or a pull of the next pending flush byte.
// Data bytes go out framed as SOH, block number, its complement, CHUNK_BYTES
// data bytes and a trailer (CRC-16/XMODEM high byte first, or an 8-bit sum,
// selected by the use_crc register at APB offset 0, reset value 1). At end
// of file a partial block is padded with 0x1A one pull at a time, followed
// by its trailer and two EOT bytes; m_transfer_done marks the second EOT.
// Timing: the front end takes one input transaction per clock while the
// QUEUE_DEPTH-entry command queue has room, and one transaction yields up to
// six output bytes. The output serializer sends one byte per clock while
// m_ready does not stall it; the sustained rate is one transaction per cycle
// for one-byte transactions (plain data bytes, pulls) while m_ready is high.
// With the queue idle, the first byte of an accepted transaction passes the
// command queue, the serializer's command register and output register to m_*.
// Depends on xbf_pkg and the xbf_front, xbf_queue and xbf_back modules.
module xmodem_block_framer_unit
    import xbf_pkg::*;
#(
    parameter int CHUNK_BYTES = 128,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_data_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_transfer_done,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic     use_crc_reg;
    logic     cfg_wr;
    logic     s_accept;
    logic     cmd_push;
    xbf_cmd_t cmd;
    logic     q_full, q_empty, q_pop;
    xbf_cmd_t q_head;

    // Config register: word 0 bit 0 is use_crc; other words read as zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, use_crc_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_crc_reg <= 1'b1;
        end else if (cfg_wr) begin
            use_crc_reg <= pwdata[0];
        end
    end

    // Every transaction is taken while the queue has room, even ones that
    // produce no bytes; only those with bytes are pushed.
    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    xbf_front #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .operation (s_operation),
        .data_byte (s_data_byte),
        .use_crc   (use_crc_reg),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    xbf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    xbf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (q_head),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_transfer_done (m_transfer_done)
    );

endmodule

### rtl/core/xbf_checker.sv
// Port-level checker for the framer, bound to the top level.
// Depends on xbf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xbf_checker
    import xbf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_frame_byte,
    input logic        m_transfer_done,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // end of transfer is always flagged on an EOT byte
    `XBF_ASSERT_IMP(a_done_on_eot, m_valid && m_transfer_done, m_frame_byte == EOT_BYTE)

    // nothing follows the final EOT
    `XBF_ASSERT_NXT(a_quiet_after_done, m_valid && m_ready && m_transfer_done, !m_valid)

    // a stalled result holds
    `XBF_ASSERT_NXT(a_out_hold, m_valid && !m_ready,
                    m_valid && $stable(m_frame_byte) && $stable(m_transfer_done))

    // a write to the mode register is visible on readback
    `XBF_ASSERT_NXT(a_cfg_readback, psel && penable && pwrite && pready && !paddr[2],
                    paddr[2] || (prdata[0] == $past(pwdata[0])))

endmodule

bind xmodem_block_framer_unit xbf_checker u_xbf_checker (.*);
